@@ sv/stu_pkg.sv @@
// ----------------------------------------------------------------------------
// stu_pkg
// Shared widths, codes and types of the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stu_pkg;

    localparam int OFFSET_WIDTH = 24;
    localparam int LINE_WIDTH   = 20;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam int TFIFO_DEPTH  = 4;
    localparam int TFIFO_AW     = $clog2(TFIFO_DEPTH);
    localparam int TFIFO_CW     = $clog2(TFIFO_DEPTH + 1);

    typedef enum logic [4:0] {
        CC_SPACE,
        CC_NEWLINE,
        CC_ALPHA,
        CC_DIGIT,
        CC_QUOTE,
        CC_LPAREN,
        CC_RPAREN,
        CC_SEMI,
        CC_PLUS,
        CC_EQ,
        CC_STAR,
        CC_SLASH,
        CC_BANG,
        CC_MINUS,
        CC_AMP,
        CC_BAR,
        CC_COLON,
        CC_GT,
        CC_OTHER
    } char_class_t;

    typedef enum logic [3:0] {
        SM_IDLE,
        SM_IDENT,
        SM_INT,
        SM_STR,
        SM_MINUS,
        SM_AMP,
        SM_BAR,
        SM_COLON,
        SM_HALT
    } scan_mode_t;

    typedef enum logic [4:0] {
        TK_IDENT,
        TK_KEYWORD,
        TK_INT,
        TK_STRING,
        TK_LPAREN,
        TK_RPAREN,
        TK_SEMI,
        TK_ARROW,
        TK_SUB,
        TK_ADD,
        TK_EQ,
        TK_MUL,
        TK_DIV,
        TK_NOT,
        TK_AND,
        TK_OR,
        TK_SCOPE,
        TK_ERROR,
        TK_END
    } token_kind_t;

    typedef struct packed {
        logic [7:0]  source_byte;
        logic        end_of_text;
        char_class_t cls;
    } cls_item_t;

    typedef struct packed {
        token_kind_t             kind;
        logic [2:0]              kwi;
        logic [OFFSET_WIDTH-1:0] start;
        logic [OFFSET_WIDTH-1:0] len;
        logic [LINE_WIDTH-1:0]   line;
        logic                    last;
    } token_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

@@ sv/stu_byte_if.sv @@
// ----------------------------------------------------------------------------
// stu_byte_if
// Source text channel: one byte or end marker per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface stu_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_text;

    modport source (output valid, output source_byte, output end_of_text, input ready);
    modport sink   (input valid, input source_byte, input end_of_text, output ready);

endinterface

`default_nettype wire

@@ sv/stu_token_if.sv @@
// ----------------------------------------------------------------------------
// stu_token_if
// Token channel: one token per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface stu_token_if;

    logic                             valid;
    logic                             ready;
    logic [4:0]                       token_kind;
    logic [2:0]                       keyword_index;
    logic [stu_pkg::OFFSET_WIDTH-1:0] start_offset;
    logic [stu_pkg::OFFSET_WIDTH-1:0] token_length;
    logic [stu_pkg::LINE_WIDTH-1:0]   line_number;
    logic                             last_result;

    modport source (
        output valid, output token_kind, output keyword_index, output start_offset,
        output token_length, output line_number, output last_result, input ready
    );
    modport sink (
        input valid, input token_kind, input keyword_index, input start_offset,
        input token_length, input line_number, input last_result, output ready
    );

endinterface

`default_nettype wire

@@ sv/stu_front.sv @@
// ----------------------------------------------------------------------------
// stu_front
// Accepts source words and tags each byte with its character class.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_front (
    stu_byte_if.sink               text,
    input  stu_pkg::queue_status_t q_status,
    output logic                   q_push,
    output stu_pkg::cls_item_t     q_item
);

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_BAR     = 8'h7C;

    function automatic stu_pkg::char_class_t classify(input logic [7:0] b);
        stu_pkg::char_class_t c;
        priority if (b == CH_NEWLINE)                          c = stu_pkg::CC_NEWLINE;
        else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) c = stu_pkg::CC_SPACE;
        else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                 (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                 b == CH_UNDER)                                c = stu_pkg::CC_ALPHA;
        else if (b >= CH_ZERO && b <= CH_NINE)                 c = stu_pkg::CC_DIGIT;
        else if (b == CH_QUOTE)                                c = stu_pkg::CC_QUOTE;
        else if (b == CH_LPAREN)                               c = stu_pkg::CC_LPAREN;
        else if (b == CH_RPAREN)                               c = stu_pkg::CC_RPAREN;
        else if (b == CH_SEMI)                                 c = stu_pkg::CC_SEMI;
        else if (b == CH_PLUS)                                 c = stu_pkg::CC_PLUS;
        else if (b == CH_EQ)                                   c = stu_pkg::CC_EQ;
        else if (b == CH_STAR)                                 c = stu_pkg::CC_STAR;
        else if (b == CH_SLASH)                                c = stu_pkg::CC_SLASH;
        else if (b == CH_BANG)                                 c = stu_pkg::CC_BANG;
        else if (b == CH_MINUS)                                c = stu_pkg::CC_MINUS;
        else if (b == CH_AMP)                                  c = stu_pkg::CC_AMP;
        else if (b == CH_BAR)                                  c = stu_pkg::CC_BAR;
        else if (b == CH_COLON)                                c = stu_pkg::CC_COLON;
        else if (b == CH_GT)                                   c = stu_pkg::CC_GT;
        else                                                   c = stu_pkg::CC_OTHER;
        return c;
    endfunction

    assign text.ready         = !q_status.full;
    assign q_push             = text.valid && !q_status.full;
    assign q_item.source_byte = text.source_byte;
    assign q_item.end_of_text = text.end_of_text;
    assign q_item.cls         = classify(text.source_byte);

endmodule

`default_nettype wire

@@ sv/stu_queue.sv @@
// ----------------------------------------------------------------------------
// stu_queue
// Short queue of classified bytes between the front and the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  stu_pkg::cls_item_t     push_item,
    input  logic                   pop,
    output stu_pkg::queue_status_t status,
    output stu_pkg::cls_item_t     head
);

    stu_pkg::cls_item_t            mem_reg [stu_pkg::QUEUE_DEPTH];
    logic [stu_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [stu_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [stu_pkg::QUEUE_CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? stu_pkg::QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? stu_pkg::QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = stu_pkg::QUEUE_CW'(count_reg + stu_pkg::QUEUE_CW'(push)
                      - stu_pkg::QUEUE_CW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == stu_pkg::QUEUE_CW'(stu_pkg::QUEUE_DEPTH));
    assign head         = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ sv/stu_back.sv @@
// ----------------------------------------------------------------------------
// stu_back
// Scanner state machine and token output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stu_pkg::queue_status_t q_status,
    input  stu_pkg::cls_item_t     q_item,
    output logic                   q_pop,
    stu_token_if.source            tokens
);

    localparam int OW         = stu_pkg::OFFSET_WIDTH;
    localparam int LW         = stu_pkg::LINE_WIDTH;
    localparam int KW_COUNT   = 5;
    localparam int KW_MAXLEN  = 7;

    typedef logic [8*KW_MAXLEN-1:0] kw_text_t;

    // keyword text left-justified, first character in the top byte
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {"using", 16'h0000},
        {"func", 24'h000000},
        {"public", 8'h00},
        "private",
        {"return", 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd4, 3'd6, 3'd7, 3'd6};

    localparam logic [OW-1:0] LEN_ZERO = '0;
    localparam logic [OW-1:0] LEN_ONE  = OW'(1);
    localparam logic [OW-1:0] LEN_TWO  = OW'(2);

    stu_pkg::scan_mode_t mode_reg, mode_next;
    logic [OW-1:0]       pos_reg, pos_next;
    logic [LW-1:0]       line_reg, line_next;
    logic [OW-1:0]       start_reg, start_next;
    logic [KW_COUNT-1:0] cand_reg, cand_next;
    logic [OW-1:0]       wlen_reg, wlen_next;

    logic                prior_valid, fresh_valid, fresh;
    stu_pkg::token_t     prior_tok, fresh_tok;
    logic                v0, v1;
    stu_pkg::token_t     t0, t1;
    stu_pkg::char_class_t cls;
    logic [7:0]          b;

    stu_pkg::token_t                tf_mem_reg [stu_pkg::TFIFO_DEPTH];
    logic [stu_pkg::TFIFO_AW-1:0]   tf_wr_reg, tf_wr_next, tf_wr_inc;
    logic [stu_pkg::TFIFO_AW-1:0]   tf_rd_reg, tf_rd_next;
    logic [stu_pkg::TFIFO_CW-1:0]   tf_count_reg, tf_count_next;
    logic                           push0, push1, tok_pop;
    stu_pkg::token_t                tf_head;

    function automatic logic [OW-1:0] sat_off(input logic [OW-1:0] v);
        return (v == '1) ? v : OW'(v + 1'b1);
    endfunction

    function automatic logic [LW-1:0] sat_line(input logic [LW-1:0] v);
        return (v == '1) ? v : LW'(v + 1'b1);
    endfunction

    function automatic logic [7:0] kw_char(input int i, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        if (int'(p) < KW_MAXLEN)
        begin
            c = KW_TEXT[i][8*(KW_MAXLEN-1-int'(p)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] cand,
                                                    input logic [OW-1:0] wlen,
                                                    input logic [7:0] ch);
        logic [KW_COUNT-1:0] keep;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            keep[i] = cand[i] && (wlen < OW'(KW_LEN[i])) && (kw_char(i, wlen[2:0]) == ch);
        end
        return keep;
    endfunction

    function automatic stu_pkg::token_t mk(input stu_pkg::token_kind_t kind,
                                           input logic [OW-1:0] start,
                                           input logic [OW-1:0] len,
                                           input logic [LW-1:0] line,
                                           input logic last);
        stu_pkg::token_t t;
        t.kind  = kind;
        t.kwi   = 3'd0;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.last  = last;
        return t;
    endfunction

    function automatic stu_pkg::token_t word_tok(input logic [KW_COUNT-1:0] cand,
                                                 input logic [OW-1:0] wlen,
                                                 input logic [OW-1:0] start,
                                                 input logic [LW-1:0] line);
        stu_pkg::token_t t;
        t = mk(stu_pkg::TK_IDENT, start, wlen, line, 1'b0);
        // lowest matching index wins
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            if (cand[i] && wlen == OW'(KW_LEN[i]))
            begin
                t.kind = stu_pkg::TK_KEYWORD;
                t.kwi  = 3'(i);
            end
        end
        return t;
    endfunction

    assign cls   = q_item.cls;
    assign b     = q_item.source_byte;
    assign q_pop = q_status.valid &&
                   (tf_count_reg <= stu_pkg::TFIFO_CW'(stu_pkg::TFIFO_DEPTH - 2));

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        start_next  = start_reg;
        cand_next   = cand_reg;
        wlen_next   = wlen_reg;
        prior_valid = 1'b0;
        prior_tok   = mk(stu_pkg::TK_END, LEN_ZERO, LEN_ZERO, line_reg, 1'b0);
        fresh_valid = 1'b0;
        fresh_tok   = mk(stu_pkg::TK_END, pos_reg, LEN_ZERO, line_reg, 1'b1);
        fresh       = 1'b0;

        if (q_item.end_of_text)
        begin
            fresh_valid = 1'b1;
            unique case (mode_reg)
                stu_pkg::SM_IDENT:
                begin
                    prior_valid = 1'b1;
                    prior_tok   = word_tok(cand_reg, wlen_reg, start_reg, line_reg);
                end
                stu_pkg::SM_INT:
                begin
                    prior_valid = 1'b1;
                    prior_tok   = mk(stu_pkg::TK_INT, start_reg, wlen_reg, line_reg, 1'b0);
                end
                stu_pkg::SM_STR:
                begin
                    prior_valid = 1'b1;
                    prior_tok   = mk(stu_pkg::TK_STRING, start_reg, wlen_reg, line_reg, 1'b0);
                end
                stu_pkg::SM_MINUS:
                begin
                    prior_valid = 1'b1;
                    prior_tok   = mk(stu_pkg::TK_SUB, start_reg, LEN_ONE, line_reg, 1'b0);
                end
                stu_pkg::SM_AMP, stu_pkg::SM_BAR, stu_pkg::SM_COLON:
                begin
                    prior_valid = 1'b1;
                    prior_tok   = mk(stu_pkg::TK_ERROR, start_reg, LEN_ONE, line_reg, 1'b1);
                    fresh_valid = 1'b0;
                end
                stu_pkg::SM_HALT:
                begin
                    fresh_valid = 1'b0;
                end
                default:
                begin
                end
            endcase
            mode_next  = stu_pkg::SM_IDLE;
            pos_next   = '0;
            line_next  = '0;
            start_next = '0;
            cand_next  = '1;
            wlen_next  = '0;
        end
        else if (mode_reg != stu_pkg::SM_HALT)
        begin
            fresh = 1'b1;
            unique case (mode_reg)
                stu_pkg::SM_IDENT:
                begin
                    if (cls == stu_pkg::CC_ALPHA || cls == stu_pkg::CC_DIGIT)
                    begin
                        cand_next = narrow(cand_reg, wlen_reg, b);
                        wlen_next = sat_off(wlen_reg);
                        fresh     = 1'b0;
                    end
                    else
                    begin
                        prior_valid = 1'b1;
                        prior_tok   = word_tok(cand_reg, wlen_reg, start_reg, line_reg);
                        mode_next   = stu_pkg::SM_IDLE;
                    end
                end
                stu_pkg::SM_INT:
                begin
                    if (cls == stu_pkg::CC_DIGIT)
                    begin
                        wlen_next = sat_off(wlen_reg);
                        fresh     = 1'b0;
                    end
                    else
                    begin
                        prior_valid = 1'b1;
                        prior_tok   = mk(stu_pkg::TK_INT, start_reg, wlen_reg, line_reg, 1'b0);
                        mode_next   = stu_pkg::SM_IDLE;
                    end
                end
                stu_pkg::SM_STR:
                begin
                    fresh = 1'b0;
                    if (cls == stu_pkg::CC_QUOTE || cls == stu_pkg::CC_NEWLINE)
                    begin
                        prior_valid = 1'b1;
                        prior_tok   = mk(stu_pkg::TK_STRING, start_reg, wlen_reg,
                                         line_reg, 1'b0);
                        mode_next   = stu_pkg::SM_IDLE;
                        if (cls == stu_pkg::CC_NEWLINE)
                        begin
                            line_next = sat_line(line_reg);
                        end
                    end
                    else
                    begin
                        wlen_next = sat_off(wlen_reg);
                    end
                end
                stu_pkg::SM_MINUS:
                begin
                    mode_next   = stu_pkg::SM_IDLE;
                    prior_valid = 1'b1;
                    if (cls == stu_pkg::CC_GT)
                    begin
                        prior_tok = mk(stu_pkg::TK_ARROW, start_reg, LEN_TWO, line_reg, 1'b0);
                        fresh     = 1'b0;
                    end
                    else
                    begin
                        prior_tok = mk(stu_pkg::TK_SUB, start_reg, LEN_ONE, line_reg, 1'b0);
                    end
                end
                stu_pkg::SM_AMP, stu_pkg::SM_BAR, stu_pkg::SM_COLON:
                begin
                    fresh       = 1'b0;
                    prior_valid = 1'b1;
                    if (mode_reg == stu_pkg::SM_AMP && cls == stu_pkg::CC_AMP)
                    begin
                        prior_tok = mk(stu_pkg::TK_AND, start_reg, LEN_TWO, line_reg, 1'b0);
                        mode_next = stu_pkg::SM_IDLE;
                    end
                    else if (mode_reg == stu_pkg::SM_BAR && cls == stu_pkg::CC_BAR)
                    begin
                        prior_tok = mk(stu_pkg::TK_OR, start_reg, LEN_TWO, line_reg, 1'b0);
                        mode_next = stu_pkg::SM_IDLE;
                    end
                    else if (mode_reg == stu_pkg::SM_COLON && cls == stu_pkg::CC_COLON)
                    begin
                        prior_tok = mk(stu_pkg::TK_SCOPE, start_reg, LEN_TWO, line_reg, 1'b0);
                        mode_next = stu_pkg::SM_IDLE;
                    end
                    else
                    begin
                        prior_tok = mk(stu_pkg::TK_ERROR, start_reg, LEN_ONE, line_reg, 1'b1);
                        mode_next = stu_pkg::SM_HALT;
                    end
                end
                default:
                begin
                    mode_next = stu_pkg::SM_IDLE;
                end
            endcase

            if (fresh)
            begin
                unique case (cls)
                    stu_pkg::CC_LPAREN, stu_pkg::CC_RPAREN, stu_pkg::CC_SEMI,
                    stu_pkg::CC_PLUS, stu_pkg::CC_EQ, stu_pkg::CC_STAR,
                    stu_pkg::CC_SLASH, stu_pkg::CC_BANG:
                    begin
                        fresh_valid = 1'b1;
                        fresh_tok   = mk(stu_pkg::TK_LPAREN, pos_reg, LEN_ONE, line_reg, 1'b0);
                        unique case (cls)
                            stu_pkg::CC_LPAREN: fresh_tok.kind = stu_pkg::TK_LPAREN;
                            stu_pkg::CC_RPAREN: fresh_tok.kind = stu_pkg::TK_RPAREN;
                            stu_pkg::CC_SEMI:   fresh_tok.kind = stu_pkg::TK_SEMI;
                            stu_pkg::CC_PLUS:   fresh_tok.kind = stu_pkg::TK_ADD;
                            stu_pkg::CC_EQ:     fresh_tok.kind = stu_pkg::TK_EQ;
                            stu_pkg::CC_STAR:   fresh_tok.kind = stu_pkg::TK_MUL;
                            stu_pkg::CC_SLASH:  fresh_tok.kind = stu_pkg::TK_DIV;
                            default:            fresh_tok.kind = stu_pkg::TK_NOT;
                        endcase
                    end
                    stu_pkg::CC_SPACE:
                    begin
                    end
                    stu_pkg::CC_NEWLINE:
                    begin
                        line_next = sat_line(line_reg);
                    end
                    stu_pkg::CC_ALPHA:
                    begin
                        mode_next  = stu_pkg::SM_IDENT;
                        start_next = pos_reg;
                        cand_next  = narrow('1, LEN_ZERO, b);
                        wlen_next  = LEN_ONE;
                    end
                    stu_pkg::CC_DIGIT:
                    begin
                        mode_next  = stu_pkg::SM_INT;
                        start_next = pos_reg;
                        wlen_next  = LEN_ONE;
                    end
                    stu_pkg::CC_QUOTE:
                    begin
                        mode_next  = stu_pkg::SM_STR;
                        start_next = sat_off(pos_reg);
                        wlen_next  = LEN_ZERO;
                    end
                    stu_pkg::CC_MINUS:
                    begin
                        mode_next  = stu_pkg::SM_MINUS;
                        start_next = pos_reg;
                    end
                    stu_pkg::CC_AMP:
                    begin
                        mode_next  = stu_pkg::SM_AMP;
                        start_next = pos_reg;
                    end
                    stu_pkg::CC_BAR:
                    begin
                        mode_next  = stu_pkg::SM_BAR;
                        start_next = pos_reg;
                    end
                    stu_pkg::CC_COLON:
                    begin
                        mode_next  = stu_pkg::SM_COLON;
                        start_next = pos_reg;
                    end
                    default:
                    begin
                        // unexpected byte, including a lone '>'
                        fresh_valid = 1'b1;
                        fresh_tok   = mk(stu_pkg::TK_ERROR, pos_reg, LEN_ONE, line_reg, 1'b1);
                        mode_next   = stu_pkg::SM_HALT;
                    end
                endcase
            end
            pos_next = sat_off(pos_reg);
        end

        t0 = prior_valid ? prior_tok : fresh_tok;
        t1 = fresh_tok;
        v0 = prior_valid || fresh_valid;
        v1 = prior_valid && fresh_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stu_pkg::SM_IDLE;
            pos_reg   <= '0;
            line_reg  <= '0;
            start_reg <= '0;
            cand_reg  <= '1;
            wlen_reg  <= '0;
        end
        else if (q_pop)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            cand_reg  <= cand_next;
            wlen_reg  <= wlen_next;
        end
    end

    // token output queue, takes up to two words per scanned byte
    assign push0     = q_pop && v0;
    assign push1     = q_pop && v1;
    assign tok_pop   = tokens.valid && tokens.ready;
    assign tf_wr_inc = stu_pkg::TFIFO_AW'(tf_wr_reg + 1'b1);

    always_comb
    begin
        tf_wr_next    = stu_pkg::TFIFO_AW'(tf_wr_reg + stu_pkg::TFIFO_AW'(push0)
                        + stu_pkg::TFIFO_AW'(push1));
        tf_rd_next    = tok_pop ? stu_pkg::TFIFO_AW'(tf_rd_reg + 1'b1) : tf_rd_reg;
        tf_count_next = stu_pkg::TFIFO_CW'(tf_count_reg + stu_pkg::TFIFO_CW'(push0)
                        + stu_pkg::TFIFO_CW'(push1) - stu_pkg::TFIFO_CW'(tok_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tf_wr_reg    <= '0;
            tf_rd_reg    <= '0;
            tf_count_reg <= '0;
        end
        else
        begin
            tf_wr_reg    <= tf_wr_next;
            tf_rd_reg    <= tf_rd_next;
            tf_count_reg <= tf_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            tf_mem_reg[tf_wr_reg] <= t0;
        end
        if (push1)
        begin
            tf_mem_reg[tf_wr_inc] <= t1;
        end
    end

    assign tf_head              = tf_mem_reg[tf_rd_reg];
    assign tokens.valid         = (tf_count_reg != '0);
    assign tokens.token_kind    = tf_head.kind;
    assign tokens.keyword_index = tf_head.kwi;
    assign tokens.start_offset  = tf_head.start;
    assign tokens.token_length  = tf_head.len;
    assign tokens.line_number   = tf_head.line;
    assign tokens.last_result   = tf_head.last;

`ifndef SYNTHESIS
    a_tf_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tf_count_reg <= stu_pkg::TFIFO_CW'(stu_pkg::TFIFO_DEPTH))
        else $error("token queue overflow");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_item.end_of_text && mode_reg == stu_pkg::SM_HALT) |-> !v0)
        else $error("halted scanner emitted a token");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.end_of_text) |=>
            (mode_reg == stu_pkg::SM_IDLE && pos_reg == '0 && line_reg == '0 &&
             cand_reg == '1 && wlen_reg == '0))
        else $error("scanner not rearmed after end of text");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> !t0.last)
        else $error("closing token followed by another token");
`endif

endmodule

`default_nettype wire

@@ sv/source_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle unless held; keyword flags update in parallel
// the completing byte is registered in the byte queue, then its token in the
// token queue; the scanner holds its byte while the token queue is more than
// half full; a byte yields up to two tokens; they leave one per cycle if ready
// reset: all queues empty, scanner idle at offset zero and line zero
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    stu_byte_if.sink    text,
    stu_token_if.source tokens
);

    stu_pkg::queue_status_t q_status;
    stu_pkg::cls_item_t     q_in_item;
    stu_pkg::cls_item_t     q_head;
    logic                   q_push;
    logic                   q_pop;

    stu_front u_front (
        .text     (text),
        .q_status (q_status),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    stu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .status    (q_status),
        .head      (q_head)
    );

    stu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .tokens   (tokens)
    );

endmodule

`default_nettype wire

@@ dv/source_tokenizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// source_tokenizer_unit_tb
// Streams source texts into the tokenizer, one byte or end marker per word,
// and checks every token against a scanner modeled in the bench. Directed
// texts cover token kinds other than IDENT and AND, and the error paths;
// random texts of well-formed pieces, broken pairs and bad bytes then run
// under random stalls on both channels, and a final stretch has no stalls.
// ----------------------------------------------------------------------------
module source_tokenizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = stu_pkg::OFFSET_WIDTH;
    localparam int LW = stu_pkg::LINE_WIDTH;

    logic clk = 1'b0;
    logic rst_n;

    stu_byte_if  text_ch ();
    stu_token_if tok_ch ();

    source_tokenizer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    string keyword_spelling [5] = '{"using", "func", "public", "private", "return"};

    // scanner state mirrored by the bench
    stu_pkg::scan_mode_t cur_mode;
    logic [OW-1:0]       cur_pos;
    logic [LW-1:0]       cur_line;
    logic [OW-1:0]       tok_start;
    logic [4:0]          kw_cand;
    logic [OW-1:0]       word_len;

    stu_pkg::token_t expected_tokens [$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int text_gap_odds  = 0;
    int token_stall_odds = 0;

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_legal_byte(input logic [7:0] b);
        if (is_alpha(b) || is_digit(b) || is_space(b))
            return 1'b1;
        case (b)
            "_", "(", ")", ";", "-", "+", "=", "*", "/", "!", "&", "|", ":", "\"":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [OW-1:0] offset_inc(input logic [OW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LW-1:0] line_inc(input logic [LW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void clear_scanner();
        cur_mode  = stu_pkg::SM_IDLE;
        cur_pos   = '0;
        cur_line  = '0;
        tok_start = '0;
        kw_cand   = '1;
        word_len  = '0;
    endfunction

    function automatic void push_token(input stu_pkg::token_kind_t kind, input logic [2:0] kwi,
                                       input logic [OW-1:0] start, input logic [OW-1:0] len,
                                       input logic last);
        stu_pkg::token_t t;
        t.kind  = kind;
        t.kwi   = kwi;
        t.start = start;
        t.len   = len;
        t.line  = cur_line;
        t.last  = last;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void flush_word();
        for (int i = 0; i < 5; i++)
        begin
            if (kw_cand[i] && word_len == keyword_spelling[i].len())
            begin
                push_token(stu_pkg::TK_KEYWORD, 3'(i), tok_start, word_len, 1'b0);
                return;
            end
        end
        push_token(stu_pkg::TK_IDENT, 3'd0, tok_start, word_len, 1'b0);
    endfunction

    function automatic void narrow_keywords(input logic [7:0] b);
        logic [4:0] keep;
        keep = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (kw_cand[i] && word_len < keyword_spelling[i].len()
                && keyword_spelling[i][int'(word_len)] == b)
                keep[i] = 1'b1;
        end
        kw_cand = keep;
    endfunction

    function automatic void start_token(input logic [7:0] b);
        stu_pkg::token_kind_t single;
        case (b)
            "(":     single = stu_pkg::TK_LPAREN;
            ")":     single = stu_pkg::TK_RPAREN;
            ";":     single = stu_pkg::TK_SEMI;
            "+":     single = stu_pkg::TK_ADD;
            "=":     single = stu_pkg::TK_EQ;
            "*":     single = stu_pkg::TK_MUL;
            "/":     single = stu_pkg::TK_DIV;
            "!":     single = stu_pkg::TK_NOT;
            default: single = stu_pkg::TK_END;
        endcase
        if (single != stu_pkg::TK_END)
            push_token(single, 3'd0, cur_pos, OW'(1), 1'b0);
        else if (is_space(b))
        begin
            if (b == 8'h0A)
                cur_line = line_inc(cur_line);
        end
        else if (is_alpha(b) || b == "_")
        begin
            cur_mode  = stu_pkg::SM_IDENT;
            tok_start = cur_pos;
            kw_cand   = '1;
            word_len  = '0;
            narrow_keywords(b);
            word_len  = OW'(1);
        end
        else if (is_digit(b))
        begin
            cur_mode  = stu_pkg::SM_INT;
            tok_start = cur_pos;
            word_len  = OW'(1);
        end
        else if (b == "\"")
        begin
            cur_mode  = stu_pkg::SM_STR;
            tok_start = offset_inc(cur_pos);
            word_len  = '0;
        end
        else if (b == "-" || b == "&" || b == "|" || b == ":")
        begin
            cur_mode  = (b == "-") ? stu_pkg::SM_MINUS : (b == "&") ? stu_pkg::SM_AMP
                      : (b == "|") ? stu_pkg::SM_BAR : stu_pkg::SM_COLON;
            tok_start = cur_pos;
        end
        else
        begin
            push_token(stu_pkg::TK_ERROR, 3'd0, cur_pos, OW'(1), 1'b1);
            cur_mode = stu_pkg::SM_HALT;
        end
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic eot);
        logic                 fresh;
        logic [7:0]           partner;
        stu_pkg::token_kind_t pair_kind;
        fresh = 1'b1;
        if (eot)
        begin
            case (cur_mode)
                stu_pkg::SM_HALT:
                begin
                    clear_scanner();
                    return;
                end
                stu_pkg::SM_IDENT: flush_word();
                stu_pkg::SM_INT:
                    push_token(stu_pkg::TK_INT, 3'd0, tok_start, word_len, 1'b0);
                stu_pkg::SM_STR:
                    push_token(stu_pkg::TK_STRING, 3'd0, tok_start, word_len, 1'b0);
                stu_pkg::SM_MINUS:
                    push_token(stu_pkg::TK_SUB, 3'd0, tok_start, OW'(1), 1'b0);
                stu_pkg::SM_AMP, stu_pkg::SM_BAR, stu_pkg::SM_COLON:
                begin
                    push_token(stu_pkg::TK_ERROR, 3'd0, tok_start, OW'(1), 1'b1);
                    clear_scanner();
                    return;
                end
                default: ;
            endcase
            push_token(stu_pkg::TK_END, 3'd0, cur_pos, OW'(0), 1'b1);
            clear_scanner();
            return;
        end

        case (cur_mode)
            stu_pkg::SM_HALT:
                return;
            stu_pkg::SM_IDENT:
            begin
                if (is_alpha(b) || is_digit(b) || b == "_")
                begin
                    narrow_keywords(b);
                    word_len = offset_inc(word_len);
                    fresh = 1'b0;
                end
                else
                begin
                    flush_word();
                    cur_mode = stu_pkg::SM_IDLE;
                end
            end
            stu_pkg::SM_INT:
            begin
                if (is_digit(b))
                begin
                    word_len = offset_inc(word_len);
                    fresh = 1'b0;
                end
                else
                begin
                    push_token(stu_pkg::TK_INT, 3'd0, tok_start, word_len, 1'b0);
                    cur_mode = stu_pkg::SM_IDLE;
                end
            end
            stu_pkg::SM_STR:
            begin
                fresh = 1'b0;
                if (b == "\"" || b == 8'h0A)
                begin
                    push_token(stu_pkg::TK_STRING, 3'd0, tok_start, word_len, 1'b0);
                    cur_mode = stu_pkg::SM_IDLE;
                    if (b == 8'h0A)
                        cur_line = line_inc(cur_line);
                end
                else
                    word_len = offset_inc(word_len);
            end
            stu_pkg::SM_MINUS:
            begin
                cur_mode = stu_pkg::SM_IDLE;
                if (b == ">")
                begin
                    push_token(stu_pkg::TK_ARROW, 3'd0, tok_start, OW'(2), 1'b0);
                    fresh = 1'b0;
                end
                else
                    push_token(stu_pkg::TK_SUB, 3'd0, tok_start, OW'(1), 1'b0);
            end
            stu_pkg::SM_AMP, stu_pkg::SM_BAR, stu_pkg::SM_COLON:
            begin
                partner   = (cur_mode == stu_pkg::SM_AMP) ? "&"
                          : (cur_mode == stu_pkg::SM_BAR) ? "|" : ":";
                pair_kind = (cur_mode == stu_pkg::SM_AMP) ? stu_pkg::TK_AND
                          : (cur_mode == stu_pkg::SM_BAR) ? stu_pkg::TK_OR
                          : stu_pkg::TK_SCOPE;
                fresh = 1'b0;
                if (b == partner)
                begin
                    push_token(pair_kind, 3'd0, tok_start, OW'(2), 1'b0);
                    cur_mode = stu_pkg::SM_IDLE;
                end
                else
                begin
                    push_token(stu_pkg::TK_ERROR, 3'd0, tok_start, OW'(1), 1'b1);
                    cur_mode = stu_pkg::SM_HALT;
                end
            end
            default:
                cur_mode = stu_pkg::SM_IDLE;
        endcase

        if (fresh)
            start_token(b);
        cur_pos = offset_inc(cur_pos);
    endfunction

    // ---- byte channel ----

    task automatic send_word(input logic [7:0] b, input logic eot);
        if (text_gap_odds != 0 && $urandom_range(0, text_gap_odds - 1) == 0)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.source_byte <= b;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (text_ch.ready !== 1'b1)
            @(posedge clk);
        predict_word(b, eot);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic end_text();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_tokens.size() != 0);
    endtask

    // ---- token channel ----

    initial
    begin : token_sink
        int stall_left;
        stall_left = 0;
        tok_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && token_stall_odds != 0
                && $urandom_range(0, token_stall_odds - 1) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left != 0)
            begin
                tok_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                tok_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : token_check
        stu_pkg::token_t want;
        if (rst_n === 1'b1 && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
        begin
            if (expected_tokens.size() == 0)
                log_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                       tok_ch.token_kind, tok_ch.start_offset));
            else
            begin
                want = expected_tokens.pop_front();
                if (tok_ch.token_kind !== 5'(want.kind))
                    log_mismatch($sformatf("token_kind got %0d expected %0d (%s at %0d)",
                                           tok_ch.token_kind, want.kind, want.kind.name(),
                                           want.start));
                if (tok_ch.keyword_index !== want.kwi)
                    log_mismatch($sformatf("keyword_index got %0d expected %0d at %0d",
                                           tok_ch.keyword_index, want.kwi, want.start));
                if (tok_ch.start_offset !== want.start)
                    log_mismatch($sformatf("start_offset got %0d expected %0d",
                                           tok_ch.start_offset, want.start));
                if (tok_ch.token_length !== want.len)
                    log_mismatch($sformatf("token_length got %0d expected %0d at %0d",
                                           tok_ch.token_length, want.len, want.start));
                if (tok_ch.line_number !== want.line)
                    log_mismatch($sformatf("line_number got %0d expected %0d at %0d",
                                           tok_ch.line_number, want.line, want.start));
                if (tok_ch.last_result !== want.last)
                    log_mismatch($sformatf("last_result got %0d expected %0d at %0d",
                                           tok_ch.last_result, want.last, want.start));
            end
        end
    end

    // ---- random text pieces ----

    function automatic logic [7:0] rand_ident_start();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_ident_char();
        if ($urandom_range(0, 4) == 0)
            return 8'("0" + $urandom_range(0, 9));
        return rand_ident_start();
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 8;
            default: return 25;
        endcase
    endfunction

    task automatic send_ident();
        string w;
        w = keyword_spelling[$urandom_range(0, 4)];
        case ($urandom_range(0, 5))
            0, 1: send_chars(w);
            2:
            begin
                send_chars(w);
                send_word(rand_ident_char(), 1'b0);
            end
            3: send_chars(w.substr(0, $urandom_range(0, w.len() - 2)));
            4:
            begin
                send_word(8'(w[0] - 8'd32), 1'b0);
                send_chars(w.substr(1, w.len() - 1));
            end
            default:
            begin
                send_word(rand_ident_start(), 1'b0);
                repeat ($urandom_range(0, 7))
                    send_word(rand_ident_char(), 1'b0);
            end
        endcase
    endtask

    task automatic send_string_body();
        logic [7:0] c;
        send_word("\"", 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == "\"" || c == 8'h0A);
            send_word(c, 1'b0);
        end
    endtask

    task automatic send_piece();
        string singles;
        singles = "()+=*/!;";
        case ($urandom_range(0, 9))
            0, 1, 2: send_ident();
            3:
                repeat ($urandom_range(1, 6))
                    send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
            4:
            begin
                send_string_body();
                send_word(($urandom_range(0, 4) == 0) ? 8'h0A : 8'("\""), 1'b0);
            end
            5, 6: send_word(singles[$urandom_range(0, 7)], 1'b0);
            7, 8:
                case ($urandom_range(0, 3))
                    0:       send_chars("->");
                    1:       send_chars("&&");
                    2:       send_chars("||");
                    default: send_chars("::");
                endcase
            default: send_word("-", 1'b0);
        endcase
        repeat ($urandom_range(0, 2))
            case ($urandom_range(0, 5))
                0:       send_word(" ", 1'b0);
                1:       send_word(8'h0A, 1'b0);
                2:       send_word(8'h09, 1'b0);
                3:       send_word(8'h0D, 1'b0);
                4:       send_word(8'h0B, 1'b0);
                default: send_word(8'h0C, 1'b0);
            endcase
    endtask

    task automatic send_broken_tail();
        logic [7:0] c;
        logic [7:0] lone;
        case ($urandom_range(0, 2))
            0:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (is_legal_byte(c));
                send_word(c, 1'b0);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       lone = "&";
                    1:       lone = "|";
                    default: lone = ":";
                endcase
                send_word(lone, 1'b0);
                if ($urandom_range(0, 2) != 0)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == lone);
                    send_word(c, 1'b0);
                end
            end
        endcase
        repeat ($urandom_range(0, 3))
            send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_random_text();
        int tail;
        repeat ($urandom_range(0, 10))
            send_piece();
        tail = $urandom_range(0, 9);
        if (tail == 0)
            send_broken_tail();
        else if (tail == 1)
            send_string_body();
        end_text();
    endtask

    // ---- tests ----

    task automatic test_token_kinds();
        text_gap_odds    = 4;
        token_stall_odds = 4;
        send_chars("public\"s\n(7)+=*/!->||::;-\"z");
        end_text();
        wait_drained();
    endtask

    task automatic test_broken_pairs();
        send_chars("&");
        end_text();
        send_chars("|x");
        end_text();
        wait_drained();
    endtask

    task automatic test_bad_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        end_text();
        end_text();
        wait_drained();
    endtask

    task automatic test_random_texts(input int n_words);
        int target;
        target = bytes_sent + n_words;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                text_gap_odds    = pick_odds();
                token_stall_odds = pick_odds();
            end
            send_random_text();
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_steady_stream(input int n_words);
        int target;
        text_gap_odds    = 0;
        token_stall_odds = 0;
        target = bytes_sent + n_words;
        while (bytes_sent < target)
            send_random_text();
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.source_byte = 8'h00;
        text_ch.end_of_text = 1'b0;
        clear_scanner();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_token_kinds();
        test_broken_pairs();
        test_bad_bytes();
        test_random_texts(1100);
        test_steady_stream(200);

        repeat (16) @(negedge clk);
        if (expected_tokens.size() != 0)
            log_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d tokens outstanding", expected_tokens.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
